/* src/seven_segment_scan_driver_core_defines.svh */
// Assertion helpers shared by the scan driver modules.
// Each macro expects clk_i and rst_ni in scope.
`ifndef SEVEN_SEGMENT_SCAN_DRIVER_CORE_DEFINES_SVH
`define SEVEN_SEGMENT_SCAN_DRIVER_CORE_DEFINES_SVH

// Same-cycle implication, off during reset
`define SSD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset
`define SSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/ssd_pkg.sv */
package ssd_pkg;

  // Display geometry
  localparam int unsigned DIGIT_COUNT = 6;
  localparam int unsigned POS_W       = 3;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(DIGIT_COUNT - 1);

  // Field widths
  localparam int unsigned VALUE_W = 24;
  localparam int unsigned GRID_W  = 8;
  localparam int unsigned SEG_W   = 7;
  localparam int unsigned DIGIT_W = 4;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Reciprocals for value / 10^p: ceil(2^k / 10^p), k = 24 + ceil(log2(10^p)).
  // Exact for every 24-bit value since the rounding error stays below 2^k / 2^24.
  localparam int unsigned RECIP_W = 25;
  localparam int unsigned PROD1_W = VALUE_W + RECIP_W;
  localparam int unsigned SHIFT_W = 6;

  localparam logic [RECIP_W-1:0] PLACE_RECIP [8] = '{
    RECIP_W'(((64'd1 << 24) + 64'd0) / 64'd1),
    RECIP_W'(((64'd1 << 28) + 64'd9) / 64'd10),
    RECIP_W'(((64'd1 << 31) + 64'd99) / 64'd100),
    RECIP_W'(((64'd1 << 34) + 64'd999) / 64'd1000),
    RECIP_W'(((64'd1 << 38) + 64'd9999) / 64'd10000),
    RECIP_W'(((64'd1 << 41) + 64'd99999) / 64'd100000),
    RECIP_W'(((64'd1 << 44) + 64'd999999) / 64'd1000000),
    RECIP_W'(((64'd1 << 48) + 64'd9999999) / 64'd10000000)
  };

  localparam logic [SHIFT_W-1:0] PLACE_SHIFT [8] = '{
    6'd24, 6'd28, 6'd31, 6'd34, 6'd38, 6'd41, 6'd44, 6'd48
  };

  // Divide by ten: ceil(2^27 / 10), exact for quotients below 2^26
  localparam int unsigned DIV10_RECIP_W = 24;
  localparam int unsigned PROD2_W       = VALUE_W + DIV10_RECIP_W;
  localparam int unsigned DIV10_SHIFT   = 27;
  localparam int unsigned TENS_W        = 21;
  localparam logic [DIV10_RECIP_W-1:0] DIV10_RECIP =
    DIV10_RECIP_W'(((64'd1 << 27) + 64'd9) / 64'd10);

  // One scan beat after classification
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   pos;
    logic               top;
  } ssd_item_t;

  // Common-cathode segment code, g..a; blank for anything above nine
  function automatic logic [SEG_W-1:0] seg_code(input logic [DIGIT_W-1:0] digit);
    logic [SEG_W-1:0] code;
    case (digit)
      4'd0:    code = 7'h3f;
      4'd1:    code = 7'h06;
      4'd2:    code = 7'h5b;
      4'd3:    code = 7'h4f;
      4'd4:    code = 7'h66;
      4'd5:    code = 7'h6d;
      4'd6:    code = 7'h7d;
      4'd7:    code = 7'h07;
      4'd8:    code = 7'h7f;
      4'd9:    code = 7'h6f;
      default: code = 7'h00;
    endcase
    return code;
  endfunction

endpackage

/* src/ssd_front.sv */
`include "seven_segment_scan_driver_core_defines.svh"

module ssd_front import ssd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [VALUE_W-1:0]  in_value_i,
  output logic                push_o,
  input  logic                push_ready_i,
  output ssd_item_t           push_item_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic             accept;

  // Take a beat whenever the queue has room
  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;
  assign push_o     = accept;

  // Tag the beat with its place and mark the top place
  always_comb begin
    push_item_o.value = in_value_i;
    push_item_o.pos   = pos_q;
    push_item_o.top   = (pos_q == LAST_POS);
  end

  // Advance the scan position, wrapping after the top place
  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      pos_d = (pos_q == LAST_POS) ? '0 : pos_q + POS_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  `SSD_ASSERT_NEXT(a_pos_advance, accept,
    pos_q == (($past(pos_q) == LAST_POS) ? POS_W'(0) : POS_W'($past(pos_q) + POS_W'(1))),
    "scan position did not advance")

endmodule

/* src/ssd_queue.sv */
`include "seven_segment_scan_driver_core_defines.svh"

module ssd_queue import ssd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  ssd_item_t push_item_i,
  output logic      push_ready_o,
  input  logic      pop_i,
  output logic      pop_valid_o,
  output ssd_item_t pop_item_o
);

  ssd_item_t         entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = entry_q[rd_ptr_q];

  // Store pushed beats
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

  // Move pointers and track fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

  `SSD_ASSERT_IMPLIES(a_no_overflow, count_q == QCNT_W'(QUEUE_DEPTH), !push_i,
    "push into full queue")
  `SSD_ASSERT_IMPLIES(a_empty_ptrs, count_q == '0, (wr_ptr_q == rd_ptr_q) && !pop_i,
    "empty queue out of step")

endmodule

/* src/ssd_back.sv */
`include "seven_segment_scan_driver_core_defines.svh"

module ssd_back import ssd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  input  ssd_item_t          pop_item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [GRID_W-1:0]  grid_drive_o,
  output logic [SEG_W-1:0]   segment_code_o,
  output logic [POS_W-1:0]   place_index_o
);

  logic                 advance;

  logic                 s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic [PROD1_W-1:0]   s1_prod_q;
  logic [POS_W-1:0]     s1_pos_q, s2_pos_q, s3_pos_q;
  logic                 s1_top_q, s2_top_q, s3_top_q;
  logic [VALUE_W-1:0]   s2_quot_q, s3_quot_q;
  logic [PROD2_W-1:0]   s3_prod_q;

  logic [PROD1_W-1:0]   s1_prod_d;
  logic [VALUE_W-1:0]   s2_quot_d;
  logic [PROD2_W-1:0]   s3_prod_d;
  logic [TENS_W-1:0]    tens;
  logic [VALUE_W-1:0]   low_rem;
  logic [DIGIT_W-1:0]   digit;
  logic                 blank;

  logic [GRID_W-1:0]    grid_d, grid_q;
  logic [SEG_W-1:0]     seg_d, seg_q;
  logic [POS_W-1:0]     place_q;

  // Whole pipe moves while the output slot is free or being drained
  assign advance = !out_valid_q || out_ready_i;
  assign pop_o   = advance && pop_valid_i;

  // Stage 1: multiply by the reciprocal of 10^place
  assign s1_prod_d = PROD1_W'(pop_item_i.value) * PROD1_W'(PLACE_RECIP[pop_item_i.pos]);

  // Stage 2: drop the fraction to get value / 10^place
  assign s2_quot_d = VALUE_W'(s1_prod_q >> PLACE_SHIFT[s1_pos_q]);

  // Stage 3: multiply by the reciprocal of ten
  assign s3_prod_d = PROD2_W'(s2_quot_q) * PROD2_W'(DIV10_RECIP);

  // Output: remainder mod ten, top place keeps the whole quotient
  always_comb begin
    tens    = TENS_W'(s3_prod_q >> DIV10_SHIFT);
    low_rem = s3_quot_q - (VALUE_W'({tens, 3'b000}) + VALUE_W'({tens, 1'b0}));
    if (s3_top_q) begin
      blank = (s3_quot_q > VALUE_W'(9));
      digit = s3_quot_q[DIGIT_W-1:0];
    end else begin
      blank = 1'b0;
      digit = low_rem[DIGIT_W-1:0];
    end
    seg_d  = blank ? '0 : seg_code(digit);
    grid_d = ~(GRID_W'(1) << (LAST_POS - s3_pos_q));
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= pop_valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_prod_q <= s1_prod_d;
      s1_pos_q  <= pop_item_i.pos;
      s1_top_q  <= pop_item_i.top;
      s2_quot_q <= s2_quot_d;
      s2_pos_q  <= s1_pos_q;
      s2_top_q  <= s1_top_q;
      s3_prod_q <= s3_prod_d;
      s3_quot_q <= s2_quot_q;
      s3_pos_q  <= s2_pos_q;
      s3_top_q  <= s2_top_q;
      grid_q    <= grid_d;
      seg_q     <= seg_d;
      place_q   <= s3_pos_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign grid_drive_o   = grid_q;
  assign segment_code_o = seg_q;
  assign place_index_o  = place_q;

  `SSD_ASSERT_IMPLIES(a_blank_top_only, out_valid_q && (seg_q == '0),
    place_q == LAST_POS, "blank digit below top place")
  `SSD_ASSERT_NEXT(a_stall_holds_s3, s3_valid_q && !advance,
    s3_valid_q && (s3_pos_q == $past(s3_pos_q)), "stage 3 lost a beat while stalled")

endmodule

/* src/seven_segment_scan_driver_core.sv */
// Six-place multiplexed seven-segment scan driver. Each input beat is one scan
// tick carrying the binary value to show; each tick yields one output beat with
// the common-cathode segment code of the current decimal place, its active-low
// grid byte (ones place on bit 5, top place on bit 0) and the place index, after
// which the scan moves to the next place, wrapping after the top one. A top-place
// quotient above nine is shown blank. The block takes one beat per clock while
// the queue has room; a result passes a pipeline of two reciprocal multipliers
// (one for the power of ten, one for the final divide by ten) and an output
// register. A four-entry queue sits between the input side and that pipeline,
// so an output stall holds the input off only once the queue fills.
module seven_segment_scan_driver_core import ssd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // [23:0] value_to_show
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o    // [7:0] grid_drive, [14:8] segment_code,
                                        // [17:15] place_index, [23:18] zero
);

  logic              push, push_ready, pop, pop_valid;
  ssd_item_t         push_item, pop_item;
  logic [GRID_W-1:0] grid_drive;
  logic [SEG_W-1:0]  segment_code;
  logic [POS_W-1:0]  place_index;

  ssd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_value_i   (s_axis_tdata_i[VALUE_W-1:0]),
    .push_o       (push),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  ssd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item)
  );

  ssd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_valid_i    (pop_valid),
    .pop_item_i     (pop_item),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .grid_drive_o   (grid_drive),
    .segment_code_o (segment_code),
    .place_index_o  (place_index)
  );

  // Pack the result beat
  assign m_axis_tdata_o = {6'b000000, place_index, segment_code, grid_drive};

endmodule
